// File: rtl/core/rate_gyro_sensor_emulator_defines.svh
// assertion macros for the rate gyro sensor emulator
`ifndef RATE_GYRO_SENSOR_EMULATOR_DEFINES_SVH
`define RATE_GYRO_SENSOR_EMULATOR_DEFINES_SVH

// combinational implication checked on every clock edge outside reset
`define RGSE_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// implication checked in the next cycle
`define RGSE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/core/rgse_pkg.sv
// types and constants shared by the rate gyro sensor emulator
package rgse_pkg;

  localparam int unsigned TrueRateW   = 32;
  localparam int unsigned NoiseW      = 16;
  localparam int unsigned CountsW     = 32;
  localparam int unsigned CfgIdxW     = 4;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned MulAW       = 64;
  localparam int unsigned MulBW       = 33;
  localparam int unsigned MulCntW     = 6;

  // multiplier bits walked for a 32-bit operand plus sign, and for a noise sample
  localparam logic [MulCntW-1:0] LenLong  = 6'd33;
  localparam logic [MulCntW-1:0] LenShort = 6'd16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_COUNTER    = 4'd0,
    CFG_CORR_COEF      = 4'd1,
    CFG_BIAS_STAB_COEF = 4'd2,
    CFG_ARW_COEF       = 4'd3,
    CFG_SCALE_FACTOR   = 4'd4,
    CFG_MAX_RATE       = 4'd5,
    CFG_RATE_TO_ANGLE  = 4'd6,
    CFG_ANG_NOISE_COEF = 4'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_POST,
    ST_CNT,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_CORR,
    OP_BSTAB,
    OP_ARW,
    OP_SCALE,
    OP_R2A,
    OP_ANG
  } op_e;

  typedef struct packed {
    logic               start;
    logic [MulCntW-1:0] len;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

// File: rtl/core/rgse_ifs.sv
// channel interfaces: sample input, result output and register write
interface rgse_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [rgse_pkg::TrueRateW-1:0]       true_rate;
  logic [rgse_pkg::NoiseW-1:0]          bias_noise;
  logic [rgse_pkg::NoiseW-1:0]          rate_noise;
  logic [rgse_pkg::NoiseW-1:0]          angle_noise;

  modport source (output valid, true_rate, bias_noise, rate_noise, angle_noise, input ready);
  modport sink   (input valid, true_rate, bias_noise, rate_noise, angle_noise, output ready);
endinterface

interface rgse_out_if;
  logic                           valid;
  logic                           ready;
  logic                           valid_res;
  logic [rgse_pkg::CountsW-1:0]   rate_counts;

  modport source (output valid, valid_res, rate_counts, input ready);
  modport sink   (input valid, valid_res, rate_counts, output ready);
endinterface

interface rgse_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rgse_pkg::CfgIdxW-1:0]   index;
  logic [rgse_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/rgse_serial_mul.sv
// radix-2 shift-add multiplier, one multiplier bit per cycle, preloaded accumulator
module rgse_serial_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rgse_pkg::mul_req_t                req_i,
  input  logic [rgse_pkg::MulAW-1:0]        a_i,
  input  logic [rgse_pkg::MulBW-1:0]        b_i,
  input  logic [rgse_pkg::MulAW-1:0]        init_i,
  output rgse_pkg::mul_stat_t               stat_o,
  output logic [rgse_pkg::MulAW-1:0]        prod_o
);

  logic                           run_q;
  logic                           done_q;
  logic [rgse_pkg::MulCntW-1:0]   cnt_q;
  logic [rgse_pkg::MulAW-1:0]     a_q;
  logic [rgse_pkg::MulBW-1:0]     b_q;
  logic [rgse_pkg::MulAW-1:0]     p_q;
  logic [rgse_pkg::MulAW-1:0]     p_d;
  logic                           last;

  assign last = (cnt_q == '0);

  // the last bit walked is the sign bit of the multiplier and has negative weight
  always_comb begin
    p_d = p_q;
    if (b_q[0]) begin
      p_d = last ? (p_q - a_q) : (p_q + a_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && last;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= req_i.len - 1'b1;
      end else if (run_q) begin
        if (last) begin
          run_q <= 1'b0;
        end
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= a_i;
      b_q <= b_i;
      p_q <= init_i;
    end else if (run_q) begin
      p_q <= p_d;
      a_q <= {a_q[rgse_pkg::MulAW-2:0], 1'b0};
      b_q <= {b_q[rgse_pkg::MulBW-1], b_q[rgse_pkg::MulBW-1:1]};
    end
  end

  assign stat_o.busy = run_q;
  assign stat_o.done = done_q;
  assign prod_o      = p_q;

endmodule

// File: rtl/core/rate_gyro_sensor_emulator.sv
// Rate gyro sensor emulator: Gauss-Markov bias, random walk, clamp, angle counts.
// Non-sampling tick: zero result in the output register in the cycle after acceptance,
// one tick per cycle while the output is not stalled. Sampling tick: the next tick waits for
// the result, computed as six products through one bit-serial shift-add multiplier (33 or 16 bits).
// Reset (async, active low): registers to defaults, counter, bias and angle to zero.
module rate_gyro_sensor_emulator (
  input  logic      clk_i,
  input  logic      rst_ni,
  rgse_in_if.sink   in_i,
  rgse_out_if.source out_o,
  rgse_cfg_if.sink  cfg_i
);

  `include "rate_gyro_sensor_emulator_defines.svh"

  // saturate a wide signed value to 32 bits
  function automatic logic [31:0] sat32(input logic [51:0] x);
    logic [31:0] r;
    if ((&x[51:31]) || !(|x[51:31])) begin
      r = x[31:0];
    end else if (x[51]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  // add one half quantum, truncate toward zero, keep the low 32 bits
  function automatic logic [31:0] counts(input logic [47:0] a);
    logic [48:0] v;
    logic        up;
    v  = {a[47], a} + 49'd32768;
    up = v[48] && (v[15:0] != 16'd0);
    return v[47:16] + {31'd0, up};
  endfunction

  rgse_pkg::state_e state_q, state_d;
  rgse_pkg::op_e    op_q, op_d;

  logic [15:0] max_counter_q;
  logic [16:0] corr_q;
  logic [30:0] bstab_q;
  logic [30:0] arw_q;
  logic [31:0] scale_q;
  logic [30:0] max_rate_q;
  logic [31:0] r2a_q;
  logic [30:0] angn_q;

  logic [15:0] tick_q;
  logic [31:0] bias_q;
  logic [47:0] angle_q;

  logic [31:0] true_rate_q;
  logic [15:0] bias_noise_q;
  logic [15:0] rate_noise_q;
  logic [15:0] angle_noise_q;
  logic [31:0] prev_q;
  logic [35:0] err_q;
  logic [31:0] meas_q;
  logic [31:0] old_cnt_q;
  logic [31:0] new_cnt_q;

  logic        out_valid_q;
  logic        out_res_q;
  logic [31:0] out_cnt_q;

  logic [15:0] tick_inc;
  logic        fire;
  logic        out_free;
  logic        in_acc;
  logic [32:0] bias_sum;
  logic [31:0] bias_mean;
  logic [47:0] meas_raw;
  logic [47:0] lim;
  logic [47:0] nlim;
  logic [31:0] meas_clamped;

  rgse_pkg::mul_req_t  mul_req;
  rgse_pkg::mul_stat_t mul_stat;
  logic [rgse_pkg::MulAW-1:0] mul_a;
  logic [rgse_pkg::MulBW-1:0] mul_b;
  logic [rgse_pkg::MulAW-1:0] mul_init;
  logic [rgse_pkg::MulAW-1:0] prod;

  assign tick_inc = tick_q + 16'd1;
  assign fire     = (tick_inc >= max_counter_q);
  assign out_free = !out_valid_q || out_o.ready;
  // a sampling tick leaves the output register alone until its result is ready
  assign in_i.ready = (state_q == rgse_pkg::ST_IDLE) && (fire || out_free);
  assign in_acc     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign bias_sum  = {bias_q[31], bias_q} + {prev_q[31], prev_q};
  assign bias_mean = bias_sum[32:1];

  assign meas_raw = prod[63:16];
  assign lim      = {17'd0, max_rate_q};
  assign nlim     = -lim;

  always_comb begin
    if ($signed(meas_raw) > $signed(lim)) begin
      meas_clamped = lim[31:0];
    end else if ($signed(meas_raw) < $signed(nlim)) begin
      meas_clamped = nlim[31:0];
    end else begin
      meas_clamped = meas_raw[31:0];
    end
  end

  rgse_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .init_i (mul_init),
    .stat_o (mul_stat),
    .prod_o (prod)
  );

  // next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      rgse_pkg::ST_IDLE: begin
        if (in_acc && fire) begin
          state_d = rgse_pkg::ST_LOAD;
          op_d    = rgse_pkg::OP_CORR;
        end
      end
      rgse_pkg::ST_LOAD: state_d = rgse_pkg::ST_MUL;
      rgse_pkg::ST_MUL: begin
        if (mul_stat.done) begin
          state_d = rgse_pkg::ST_POST;
        end
      end
      rgse_pkg::ST_POST: begin
        state_d = rgse_pkg::ST_LOAD;
        unique case (op_q)
          rgse_pkg::OP_CORR:  op_d = rgse_pkg::OP_BSTAB;
          rgse_pkg::OP_BSTAB: op_d = rgse_pkg::OP_ARW;
          rgse_pkg::OP_ARW:   op_d = rgse_pkg::OP_SCALE;
          rgse_pkg::OP_SCALE: op_d = rgse_pkg::OP_R2A;
          rgse_pkg::OP_R2A:   op_d = rgse_pkg::OP_ANG;
          default:            state_d = rgse_pkg::ST_CNT;
        endcase
      end
      rgse_pkg::ST_CNT: state_d = rgse_pkg::ST_OUT;
      rgse_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = rgse_pkg::ST_IDLE;
        end
      end
      default: state_d = rgse_pkg::ST_IDLE;
    endcase
  end

  // multiplier operands; rounding half and addends ride in the preloaded accumulator
  always_comb begin
    mul_req.start = (state_q == rgse_pkg::ST_LOAD);
    mul_req.len   = rgse_pkg::LenLong;
    mul_a         = {{32{bias_q[31]}}, bias_q};
    mul_b         = {16'd0, corr_q};
    mul_init      = 64'd32768;
    unique case (op_q)
      rgse_pkg::OP_CORR: begin
        mul_req.len = rgse_pkg::LenLong;
        mul_a       = {{32{bias_q[31]}}, bias_q};
        mul_b       = {16'd0, corr_q};
        mul_init    = 64'd32768;
      end
      rgse_pkg::OP_BSTAB: begin
        mul_req.len = rgse_pkg::LenShort;
        mul_a       = {33'd0, bstab_q};
        mul_b       = {{17{bias_noise_q[15]}}, bias_noise_q};
        mul_init    = {{20{prev_q[31]}}, prev_q, 12'h800};
      end
      rgse_pkg::OP_ARW: begin
        mul_req.len = rgse_pkg::LenShort;
        mul_a       = {33'd0, arw_q};
        mul_b       = {{17{rate_noise_q[15]}}, rate_noise_q};
        mul_init    = {{20{bias_mean[31]}}, bias_mean, 12'h800};
      end
      rgse_pkg::OP_SCALE: begin
        mul_req.len = rgse_pkg::LenLong;
        mul_a       = {{32{scale_q[31]}}, scale_q};
        mul_b       = {true_rate_q[31], true_rate_q};
        mul_init    = {{12{err_q[35]}}, err_q, 16'h8000};
      end
      rgse_pkg::OP_R2A: begin
        mul_req.len = rgse_pkg::LenLong;
        mul_a       = {{32{meas_q[31]}}, meas_q};
        mul_b       = {1'b0, r2a_q};
        mul_init    = {angle_q, 16'h8000};
      end
      rgse_pkg::OP_ANG: begin
        mul_req.len = rgse_pkg::LenShort;
        mul_a       = {33'd0, angn_q};
        mul_b       = {{17{angle_noise_q[15]}}, angle_noise_q};
        mul_init    = {{4{angle_q[47]}}, angle_q, 12'h800};
      end
      default: begin
        mul_req.len = rgse_pkg::LenLong;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= rgse_pkg::ST_IDLE;
      op_q          <= rgse_pkg::OP_CORR;
      max_counter_q <= 16'd1;
      corr_q        <= 17'd65536;
      bstab_q       <= '0;
      arw_q         <= '0;
      scale_q       <= 32'd65536;
      max_rate_q    <= 31'h7FFF_FFFF;
      r2a_q         <= 32'd65536;
      angn_q        <= '0;
      tick_q        <= '0;
      bias_q        <= '0;
      angle_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;

      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          rgse_pkg::CFG_MAX_COUNTER:    max_counter_q <= cfg_i.data[15:0];
          rgse_pkg::CFG_CORR_COEF:      corr_q        <= cfg_i.data[16:0];
          rgse_pkg::CFG_BIAS_STAB_COEF: bstab_q       <= cfg_i.data[30:0];
          rgse_pkg::CFG_ARW_COEF:       arw_q         <= cfg_i.data[30:0];
          rgse_pkg::CFG_SCALE_FACTOR:   scale_q       <= cfg_i.data;
          rgse_pkg::CFG_MAX_RATE:       max_rate_q    <= cfg_i.data[30:0];
          rgse_pkg::CFG_RATE_TO_ANGLE:  r2a_q         <= cfg_i.data;
          rgse_pkg::CFG_ANG_NOISE_COEF: angn_q        <= cfg_i.data[30:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        tick_q <= fire ? 16'd0 : tick_inc;
      end

      if (state_q == rgse_pkg::ST_POST) begin
        unique case (op_q)
          rgse_pkg::OP_BSTAB: bias_q  <= sat32(prod[63:12]);
          rgse_pkg::OP_R2A:   angle_q <= prod[63:16];
          rgse_pkg::OP_ANG:   angle_q <= prod[59:12];
          default: ;
        endcase
      end

      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if ((in_acc && !fire) || (state_q == rgse_pkg::ST_OUT && out_free)) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      true_rate_q   <= in_i.true_rate;
      bias_noise_q  <= in_i.bias_noise;
      rate_noise_q  <= in_i.rate_noise;
      angle_noise_q <= in_i.angle_noise;
      if (fire) begin
        old_cnt_q <= counts(angle_q);
      end else begin
        out_res_q <= 1'b0;
        out_cnt_q <= '0;
      end
    end

    if (state_q == rgse_pkg::ST_POST) begin
      unique case (op_q)
        rgse_pkg::OP_CORR:  prev_q <= sat32({{4{prod[63]}}, prod[63:16]});
        rgse_pkg::OP_ARW:   err_q  <= prod[47:12];
        rgse_pkg::OP_SCALE: meas_q <= meas_clamped;
        default: ;
      endcase
    end

    if (state_q == rgse_pkg::ST_CNT) begin
      new_cnt_q <= counts(angle_q);
    end

    if (state_q == rgse_pkg::ST_OUT && out_free) begin
      out_res_q <= 1'b1;
      out_cnt_q <= new_cnt_q - old_cnt_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.valid_res   = out_res_q;
  assign out_o.rate_counts = out_cnt_q;

  `RGSE_ASSERT_IMP(a_mul_start_idle, mul_req.start, !mul_stat.busy, "multiplier restarted while busy")
  `RGSE_ASSERT_IMP(a_mul_done_state, mul_stat.done, state_q == rgse_pkg::ST_MUL, "product outside wait state")
  `RGSE_ASSERT_IMP(a_idle_result_zero, out_valid_q && !out_res_q, out_cnt_q == '0, "nonzero idle result")
  `RGSE_ASSERT_NEXT(a_fire_starts_work, in_acc && fire, state_q == rgse_pkg::ST_LOAD, "sample not started")

endmodule

// File: test/tb_top.sv
// self-checking testbench for rate_gyro_sensor_emulator with a built-in gyro predictor
`timescale 1ns / 100ps

module tb_top;

  localparam logic [rgse_pkg::CfgIdxW-1:0] CfgIdxUnused = 4'd13;
  localparam int unsigned NumRandPhases = 8;
  localparam int unsigned ItemsPerPhase = 104;

  typedef struct packed {
    logic [rgse_pkg::TrueRateW-1:0] true_rate;
    logic [rgse_pkg::NoiseW-1:0]    bias_noise;
    logic [rgse_pkg::NoiseW-1:0]    rate_noise;
    logic [rgse_pkg::NoiseW-1:0]    angle_noise;
  } gyro_tick_t;

  typedef struct packed {
    logic                         valid_res;
    logic [rgse_pkg::CountsW-1:0] rate_counts;
  } gyro_sample_t;

  logic clk_i;
  logic rst_ni;

  rgse_in_if  tick_ch ();
  rgse_out_if sample_ch ();
  rgse_cfg_if cfg_ch ();

  rate_gyro_sensor_emulator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_ch),
    .out_o  (sample_ch),
    .cfg_i  (cfg_ch)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // predictor registers and state
  logic [15:0] c_max_cnt  = 16'd1;
  longint      c_corr     = 65536;
  longint      c_bstab    = 0;
  longint      c_arw      = 0;
  longint      c_scale    = 65536;
  longint      c_max_rate = 2147483647;
  longint      c_r2a      = 65536;
  longint      c_angn     = 0;
  logic [15:0] sub_cnt    = '0;
  longint      gm_bias    = 0;
  logic [47:0] angle_q48  = '0;

  gyro_tick_t   tick_q[$];
  gyro_sample_t gyro_sample_q[$];
  gyro_tick_t   cur_tick;
  int unsigned  pushed_cnt = 0;
  int unsigned  accepted_cnt = 0;
  int unsigned  err_count = 0;
  int unsigned  src_idle_pct = 0;
  int unsigned  sink_stall_pct = 0;

  function automatic longint round_shift(longint x, int n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint sat_32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // add one half, then truncate toward zero
  function automatic logic [31:0] angle_counts(longint a);
    longint v;
    longint c;
    v = a + 32768;
    c = (v >= 0) ? (v >>> 16) : -((-v) >>> 16);
    return c[31:0];
  endfunction

  function automatic void apply_cfg(logic [rgse_pkg::CfgIdxW-1:0] idx,
                                    logic [rgse_pkg::CfgDataW-1:0] val);
    case (idx)
      rgse_pkg::CFG_MAX_COUNTER:    c_max_cnt  = val[15:0];
      rgse_pkg::CFG_CORR_COEF:      c_corr     = longint'(val[16:0]);
      rgse_pkg::CFG_BIAS_STAB_COEF: c_bstab    = longint'(val[30:0]);
      rgse_pkg::CFG_ARW_COEF:       c_arw      = longint'(val[30:0]);
      rgse_pkg::CFG_SCALE_FACTOR:   c_scale    = longint'(signed'(val));
      rgse_pkg::CFG_MAX_RATE:       c_max_rate = longint'(val[30:0]);
      rgse_pkg::CFG_RATE_TO_ANGLE:  c_r2a      = longint'(val);
      rgse_pkg::CFG_ANG_NOISE_COEF: c_angn     = longint'(val[30:0]);
      default: ;
    endcase
  endfunction

  function automatic gyro_sample_t gyro_emulate(gyro_tick_t t);
    gyro_sample_t s;
    logic [15:0]  nxt;
    longint       rate, bn, rn, an;
    longint       prev, err, meas, old_ang, new_ang;
    rate = longint'(signed'(t.true_rate));
    bn   = longint'(signed'(t.bias_noise));
    rn   = longint'(signed'(t.rate_noise));
    an   = longint'(signed'(t.angle_noise));
    nxt  = sub_cnt + 16'd1;
    s    = '0;
    if (nxt < c_max_cnt) begin
      sub_cnt = nxt;
      return s;
    end
    sub_cnt = '0;
    // gauss-markov bias, then the mean of decayed old and new bias drives the rate error
    prev    = sat_32(round_shift(c_corr * gm_bias, 16));
    gm_bias = sat_32(prev + round_shift(c_bstab * bn, 12));
    err     = ((gm_bias + prev) >>> 1) + round_shift(c_arw * rn, 12);
    meas    = round_shift(c_scale * rate, 16) + err;
    if (meas > c_max_rate) meas = c_max_rate;
    if (meas < -c_max_rate) meas = -c_max_rate;
    old_ang   = longint'(signed'(angle_q48));
    new_ang   = old_ang + round_shift(meas * c_r2a, 16) + round_shift(c_angn * an, 12);
    angle_q48 = new_ang[47:0];
    new_ang   = longint'(signed'(angle_q48));
    s.valid_res   = 1'b1;
    s.rate_counts = angle_counts(new_ang) - angle_counts(old_ang);
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  // tick driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      tick_ch.valid <= 1'b0;
    end else begin
      if (tick_ch.valid && tick_ch.ready) begin
        gyro_sample_q.push_back(gyro_emulate(cur_tick));
        accepted_cnt++;
      end
      if (!tick_ch.valid || tick_ch.ready) begin
        if (tick_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_tick = tick_q.pop_front();
          tick_ch.valid       <= 1'b1;
          tick_ch.true_rate   <= cur_tick.true_rate;
          tick_ch.bias_noise  <= cur_tick.bias_noise;
          tick_ch.rate_noise  <= cur_tick.rate_noise;
          tick_ch.angle_noise <= cur_tick.angle_noise;
        end else begin
          tick_ch.valid <= 1'b0;
        end
      end
    end
  end

  // sample monitor
  always @(posedge clk_i) begin
    gyro_sample_t want;
    if (!rst_ni) begin
      sample_ch.ready <= 1'b0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        if (gyro_sample_q.size() == 0) begin
          report_mismatch("sample with no tick pending", sample_ch.rate_counts, '0);
        end else begin
          want = gyro_sample_q.pop_front();
          if (sample_ch.valid_res !== want.valid_res) begin
            report_mismatch("valid_res", 32'(sample_ch.valid_res), 32'(want.valid_res));
          end
          if (sample_ch.rate_counts !== want.rate_counts) begin
            report_mismatch("rate_counts", sample_ch.rate_counts, want.rate_counts);
          end
        end
      end
      sample_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic push_tick(logic [31:0] rate, logic [15:0] bn, logic [15:0] rn,
                           logic [15:0] an);
    gyro_tick_t t;
    t.true_rate   = rate;
    t.bias_noise  = bn;
    t.rate_noise  = rn;
    t.angle_noise = an;
    tick_q.push_back(t);
    pushed_cnt++;
  endtask

  task automatic push_random_tick();
    logic [31:0] rate;
    logic [15:0] bn, rn, an;
    if ($urandom_range(9) < 7) begin
      // plausible rates and noise within a few sigma
      rate = 32'($urandom_range(0, 2 ** 21)) - 32'(2 ** 20);
      bn   = 16'($urandom_range(0, 16384)) - 16'd8192;
      rn   = 16'($urandom_range(0, 16384)) - 16'd8192;
      an   = 16'($urandom_range(0, 16384)) - 16'd8192;
    end else begin
      rate = $urandom;
      bn   = 16'($urandom);
      rn   = 16'($urandom);
      an   = 16'($urandom);
    end
    push_tick(rate, bn, rn, an);
  endtask

  task automatic cfg_write(logic [rgse_pkg::CfgIdxW-1:0] idx,
                           logic [rgse_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    apply_cfg(idx, val);
  endtask

  // every tick yields a sample, so an empty store means the block is idle
  task automatic wait_drained();
    while (accepted_cnt != pushed_cnt || gyro_sample_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_cfg(int unsigned kind);
    logic [31:0] mc;
    case (kind)
      0: mc = 32'($urandom_range(1, 4));
      1: mc = 32'($urandom_range(0, 3));
      2: mc = 32'hFFFF;
      default: mc = '0;
    endcase
    cfg_write(rgse_pkg::CFG_MAX_COUNTER, mc);
    if (kind == 1 || kind == 3) begin
      cfg_write(rgse_pkg::CFG_CORR_COEF, $urandom);
      cfg_write(rgse_pkg::CFG_BIAS_STAB_COEF, $urandom);
      cfg_write(rgse_pkg::CFG_ARW_COEF, $urandom);
      cfg_write(rgse_pkg::CFG_SCALE_FACTOR, $urandom);
      cfg_write(rgse_pkg::CFG_MAX_RATE, $urandom);
      cfg_write(rgse_pkg::CFG_RATE_TO_ANGLE, $urandom);
      cfg_write(rgse_pkg::CFG_ANG_NOISE_COEF, $urandom);
    end else begin
      cfg_write(rgse_pkg::CFG_CORR_COEF, 32'($urandom_range(60000, 65536)));
      cfg_write(rgse_pkg::CFG_BIAS_STAB_COEF, 32'($urandom_range(0, 2 ** 12)));
      cfg_write(rgse_pkg::CFG_ARW_COEF, 32'($urandom_range(0, 2 ** 14)));
      cfg_write(rgse_pkg::CFG_SCALE_FACTOR, 32'($urandom_range(64536, 66536)));
      cfg_write(rgse_pkg::CFG_MAX_RATE, 32'($urandom_range(2 ** 16, 2 ** 24)));
      cfg_write(rgse_pkg::CFG_RATE_TO_ANGLE, 32'($urandom_range(2 ** 14, 2 ** 18)));
      cfg_write(rgse_pkg::CFG_ANG_NOISE_COEF, 32'($urandom_range(0, 2 ** 15)));
    end
  endtask

  initial begin
    int unsigned src_modes[4]  = '{0, 56, 0, 38};
    int unsigned sink_modes[4] = '{0, 0, 56, 38};
    int unsigned cfg_kinds[NumRandPhases] = '{0, 1, 0, 3, 2, 0, 1, 0};
    rst_ni              = 1'b0;
    tick_ch.valid       = 1'b0;
    tick_ch.true_rate   = '0;
    tick_ch.bias_noise  = '0;
    tick_ch.rate_noise  = '0;
    tick_ch.angle_noise = '0;
    sample_ch.ready     = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = rgse_pkg::CFG_MAX_COUNTER;
    cfg_ch.data         = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: every tick samples, unit scale, no noise
    push_tick(32'h0000_0000, 16'h0000, 16'h0000, 16'h0000);
    push_tick(32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_tick(32'h8000_0000, 16'h8000, 16'h8000, 16'h8000);
    push_tick(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_tick(32'h0000_8000, 16'h0001, 16'h0001, 16'h0001);
    wait_drained();

    // extreme gains: correlation above one, bias saturation, 48-bit angle wrap
    cfg_write(rgse_pkg::CFG_MAX_COUNTER, 32'h0000_0000);
    cfg_write(rgse_pkg::CFG_CORR_COEF, 32'hFFFF_FFFF);
    cfg_write(rgse_pkg::CFG_BIAS_STAB_COEF, 32'h7FFF_FFFF);
    cfg_write(rgse_pkg::CFG_ARW_COEF, 32'h7FFF_FFFF);
    cfg_write(rgse_pkg::CFG_SCALE_FACTOR, 32'h8000_0000);
    cfg_write(rgse_pkg::CFG_MAX_RATE, 32'h7FFF_FFFF);
    cfg_write(rgse_pkg::CFG_RATE_TO_ANGLE, 32'hFFFF_FFFF);
    cfg_write(rgse_pkg::CFG_ANG_NOISE_COEF, 32'h7FFF_FFFF);
    push_tick(32'h8000_0000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_tick(32'h8000_0000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_tick(32'h8000_0000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_tick(32'h7FFF_FFFF, 16'h8000, 16'h8000, 16'h8000);
    push_tick(32'h7FFF_FFFF, 16'h8000, 16'h8000, 16'h8000);
    push_tick(32'h7FFF_FFFF, 16'h8000, 16'h8000, 16'h8000);
    push_tick(32'h0000_0000, 16'h0000, 16'h0000, 16'h0000);
    push_tick(32'h1234_5678, 16'hA5A5, 16'h5A5A, 16'hC3C3);
    wait_drained();

    // zero rate limit clamps everything, only angle noise moves the counts
    cfg_write(rgse_pkg::CFG_CORR_COEF, 32'h0000_0000);
    cfg_write(rgse_pkg::CFG_SCALE_FACTOR, 32'h7FFF_FFFF);
    cfg_write(rgse_pkg::CFG_MAX_RATE, 32'h0000_0000);
    cfg_write(rgse_pkg::CFG_RATE_TO_ANGLE, 32'h0001_0000);
    push_tick(32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_tick(32'h8000_0000, 16'h8000, 16'h8000, 16'h8000);
    push_tick(32'h7FFF_FFFF, 16'h0000, 16'h0000, 16'h8000);
    wait_drained();

    // ignored register index, then counter lowered below the running count
    cfg_write(CfgIdxUnused, 32'h0000_0000);
    cfg_write(rgse_pkg::CFG_MAX_COUNTER, 32'hABCD_0005);
    push_tick(32'h0001_0000, 16'h1000, 16'h1000, 16'h1000);
    push_tick(32'h0001_0000, 16'h1000, 16'h1000, 16'h1000);
    push_tick(32'h0001_0000, 16'h1000, 16'h1000, 16'h1000);
    wait_drained();
    cfg_write(rgse_pkg::CFG_MAX_COUNTER, 32'h0000_0002);
    push_tick(32'hFFFF_0000, 16'hF000, 16'hF000, 16'hF000);
    push_tick(32'hFFFF_0000, 16'hF000, 16'hF000, 16'hF000);
    wait_drained();

    for (int unsigned p = 0; p < NumRandPhases; p++) begin
      random_cfg(cfg_kinds[p]);
      src_idle_pct   = src_modes[p % 4];
      sink_stall_pct = sink_modes[p % 4];
      for (int unsigned i = 0; i < ItemsPerPhase; i++) push_random_tick();
      wait_drained();
    end

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (200) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout with %0d ticks still waiting for a sample",
             pushed_cnt - accepted_cnt + gyro_sample_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
